// ===== src/tcp_connection_state_machine_defines.svh =====
// Assertion macros for the TCP connection block
`ifndef TCP_CONNECTION_STATE_MACHINE_DEFINES_SVH
`define TCP_CONNECTION_STATE_MACHINE_DEFINES_SVH

`ifndef SYNTH
`define TCSM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TCSM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TCSM_ASSERT_IMP(label, clk, rst_n, a, c)
`define TCSM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif

`endif

// ===== src/tcsm_pkg.sv =====
package tcsm_pkg;

    localparam logic [5:0] F_FIN = 6'h01;
    localparam logic [5:0] F_SYN = 6'h02;
    localparam logic [5:0] F_RST = 6'h04;
    localparam logic [5:0] F_PSH = 6'h08;
    localparam logic [5:0] F_ACK = 6'h10;
    localparam logic [5:0] F_URG = 6'h20;

    localparam logic [3:0] S_CLOSED     = 4'd0;
    localparam logic [3:0] S_LISTEN     = 4'd1;
    localparam logic [3:0] S_SYN_SENT   = 4'd2;
    localparam logic [3:0] S_SYN_RCVD   = 4'd3;
    localparam logic [3:0] S_ESTAB      = 4'd4;
    localparam logic [3:0] S_FW1        = 4'd5;
    localparam logic [3:0] S_FW2        = 4'd6;
    localparam logic [3:0] S_CLOSING    = 4'd7;
    localparam logic [3:0] S_TIME_WAIT  = 4'd8;
    localparam logic [3:0] S_CLOSE_WAIT = 4'd9;
    localparam logic [3:0] S_LAST_ACK   = 4'd10;

    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_CONNECTED = 3'd1;
    localparam logic [2:0] ST_RESET     = 3'd2;
    localparam logic [2:0] ST_ACCEPTED  = 3'd3;
    localparam logic [2:0] ST_DATA      = 3'd4;
    localparam logic [2:0] ST_DROPPED   = 3'd5;
    localparam logic [2:0] ST_REFUSED   = 3'd6;
    localparam logic [2:0] ST_PEER_FIN  = 3'd7;

    localparam logic [1:0] M_SEG    = 2'd0;
    localparam logic [1:0] M_ACTIVE = 2'd1;
    localparam logic [1:0] M_PASSIVE = 2'd2;
    localparam logic [1:0] M_CLOSE  = 2'd3;

    // event as seen by the state machine
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
        logic [15:0] win;
        logic [15:0] urg;
        logic [15:0] plen;
        logic [31:0] niss;
    } event_t;

    // front-end precomputed classification
    typedef struct packed {
        event_t      ev;
        logic [31:0] seq_plus1;
        logic [31:0] seq_plen;
        logic        plen_nz;
    } cls_t;

    // one transmit segment
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
        logic [15:0] win;
    } seg_t;

    // one result item
    typedef struct packed {
        logic        send_valid;
        seg_t        seg;
        logic [3:0]  conn_state;
        logic [2:0]  status;
        logic [15:0] deliver_offset;
        logic [15:0] deliver_len;
        logic        last;
    } result_t;

endpackage

// ===== src/tcsm_front.sv =====
// Accepts events and precomputes sums that do not depend on connection state
module tcsm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcsm_pkg::event_t    in_ev,
    output logic                q_valid,
    input  logic                q_ready,
    output tcsm_pkg::cls_t      q_data
);
    // two-entry queue toward the back end
    tcsm_pkg::cls_t q_mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;
    tcsm_pkg::cls_t cls;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = q_mem_reg[rp_reg];

    // classification sums
    always_comb begin
        cls.ev        = in_ev;
        cls.seq_plus1 = in_ev.seq + 32'd1;
        cls.seq_plen  = in_ev.seq + {16'd0, in_ev.plen};
        cls.plen_nz   = (in_ev.plen != 16'd0);
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (!push && pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wp_reg] <= cls;
    end
endmodule

// ===== src/tcsm_back.sv =====
`include "tcp_connection_state_machine_defines.svh"
// Runs the connection state machine, one event per cycle unless results stall it, and streams results
module tcsm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                q_valid,
    output logic                q_ready,
    input  tcsm_pkg::cls_t      q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcsm_pkg::result_t   out_res
);
    logic [15:0] rbs_reg;
    logic [3:0]  cs_reg, cs_n;
    logic [31:0] snd_nxt_reg, snd_nxt_n, snd_una_reg, snd_una_n;
    logic [15:0] snd_wnd_reg, snd_wnd_n;
    logic [31:0] wl1_reg, wl1_n, wl2_reg, wl2_n, iss_reg, iss_n, irs_reg, irs_n;
    logic [31:0] rcv_nxt_reg, rcv_nxt_n;
    logic [15:0] rcv_wnd_reg, rcv_wnd_n, rcv_up_reg, rcv_up_n;
    logic        pas_reg, pas_n;

    // result holding registers: up to three segments for the current event
    tcsm_pkg::seg_t tx_reg [3];
    logic [1:0]  ntx_reg, idx_reg;
    logic        busy_reg;
    logic [3:0]  rcs_reg;
    logic [2:0]  rst_reg;
    logic [15:0] roff_reg, rlen_reg;

    tcsm_pkg::seg_t tx_n [3];
    logic [1:0]  ntx;
    logic [2:0]  status;
    logic [15:0] doff, dlen;
    logic        take, fin_item;
    logic [1:0]  nres;

    assign cfg_ready = 1'b1;
    assign nres      = (ntx_reg == 2'd0) ? 2'd1 : ntx_reg;
    assign fin_item  = out_valid && out_ready && (idx_reg == nres - 2'd1);
    assign q_ready   = !busy_reg || fin_item;
    assign take      = q_valid && q_ready;
    assign out_valid = busy_reg;

    always_comb begin
        out_res.send_valid     = (idx_reg < ntx_reg);
        out_res.seg            = out_res.send_valid ? tx_reg[idx_reg] : '0;
        out_res.conn_state     = rcs_reg;
        out_res.status         = rst_reg;
        out_res.deliver_offset = roff_reg;
        out_res.deliver_len    = rlen_reg;
        out_res.last           = (idx_reg == nres - 2'd1);
    end

    // event processing
    always_comb begin
        logic [1:0]  mode;
        logic [31:0] seq, ack, lim, dseq, sp1, spl;
        logic [5:0]  flg;
        logic [15:0] acc;
        logic        ok, done, do_tail, in_data;
        logic [31:0] e_seq [3];
        logic [31:0] e_ack [3];
        logic [5:0]  e_flg [3];
        logic [1:0]  ntx_pre;
        logic [15:0] win_pre;
        mode = q_data.ev.mode;
        seq  = q_data.ev.seq;
        ack  = q_data.ev.ack;
        flg  = q_data.ev.flags;
        sp1  = q_data.seq_plus1;
        spl  = q_data.seq_plen;
        cs_n = cs_reg; snd_nxt_n = snd_nxt_reg; snd_una_n = snd_una_reg;
        snd_wnd_n = snd_wnd_reg; wl1_n = wl1_reg; wl2_n = wl2_reg;
        iss_n = iss_reg; irs_n = irs_reg; rcv_nxt_n = rcv_nxt_reg;
        rcv_wnd_n = rcv_wnd_reg; rcv_up_n = rcv_up_reg; pas_n = pas_reg;
        ntx = 2'd0; status = tcsm_pkg::ST_NONE; doff = '0; dlen = '0;
        ok = 1'b0; done = 1'b0; do_tail = 1'b0; dseq = seq; acc = '0;
        in_data = 1'b0; ntx_pre = 2'd0; win_pre = rcv_wnd_reg;
        lim = rcv_nxt_reg + {16'd0, rcv_wnd_reg};
        for (int i = 0; i < 3; i++) begin
            e_seq[i] = '0; e_ack[i] = '0; e_flg[i] = '0; tx_n[i] = '0;
        end
        unique case (mode) inside
            tcsm_pkg::M_SEG: begin
                if (cs_reg == tcsm_pkg::S_CLOSED) begin
                    if ((flg & tcsm_pkg::F_RST) == '0) begin
                        if ((flg & tcsm_pkg::F_ACK) != '0) begin
                            e_seq[0] = ack; e_flg[0] = tcsm_pkg::F_RST;
                        end else begin
                            e_ack[0] = spl;
                            e_flg[0] = tcsm_pkg::F_RST | tcsm_pkg::F_ACK;
                        end
                        ntx = 2'd1;
                    end
                    status = tcsm_pkg::ST_DROPPED;
                end else if (cs_reg == tcsm_pkg::S_LISTEN) begin
                    status = tcsm_pkg::ST_DROPPED;
                    if ((flg & tcsm_pkg::F_RST) != '0) begin
                    end else if ((flg & tcsm_pkg::F_ACK) != '0) begin
                        e_seq[0] = ack; e_flg[0] = tcsm_pkg::F_RST; ntx = 2'd1;
                    end else if ((flg & tcsm_pkg::F_SYN) != '0) begin
                        status = tcsm_pkg::ST_NONE;
                        rcv_wnd_n = rbs_reg; rcv_nxt_n = sp1; irs_n = seq;
                        iss_n = q_data.ev.niss;
                        e_seq[0] = q_data.ev.niss; e_ack[0] = sp1;
                        e_flg[0] = tcsm_pkg::F_SYN | tcsm_pkg::F_ACK; ntx = 2'd1;
                        snd_nxt_n = q_data.ev.niss + 32'd1;
                        snd_una_n = q_data.ev.niss;
                        cs_n = tcsm_pkg::S_SYN_RCVD;
                    end
                end else if (cs_reg == tcsm_pkg::S_SYN_SENT) begin
                    if ((flg & tcsm_pkg::F_ACK) != '0) begin
                        if (ack <= iss_reg || ack > snd_nxt_reg) begin
                            e_seq[0] = ack; e_flg[0] = tcsm_pkg::F_RST; ntx = 2'd1;
                            status = tcsm_pkg::ST_DROPPED; done = 1'b1;
                        end else if (snd_una_reg <= ack) begin
                            ok = 1'b1;
                        end else begin
                            status = tcsm_pkg::ST_DROPPED; done = 1'b1;
                        end
                    end
                    if (done) begin
                    end else if ((flg & tcsm_pkg::F_RST) != '0) begin
                        if (!ok) status = tcsm_pkg::ST_DROPPED;
                        else begin
                            cs_n = tcsm_pkg::S_CLOSED; status = tcsm_pkg::ST_RESET;
                        end
                    end else if ((flg & tcsm_pkg::F_SYN) != '0) begin
                        rcv_nxt_n = sp1; irs_n = seq;
                        if ((flg & tcsm_pkg::F_ACK) != '0) snd_una_n = ack;
                        if (snd_una_n > iss_reg) begin
                            cs_n = tcsm_pkg::S_ESTAB;
                            e_seq[0] = snd_nxt_reg; e_ack[0] = sp1;
                            e_flg[0] = tcsm_pkg::F_ACK; ntx = 2'd1;
                            status = tcsm_pkg::ST_CONNECTED;
                            if (q_data.plen_nz || (flg & tcsm_pkg::F_URG) != '0) begin
                                do_tail = 1'b1; dseq = sp1;
                            end
                        end else begin
                            cs_n = tcsm_pkg::S_SYN_RCVD;
                            e_seq[0] = iss_reg; e_ack[0] = sp1;
                            e_flg[0] = tcsm_pkg::F_SYN | tcsm_pkg::F_ACK; ntx = 2'd1;
                        end
                    end else begin
                        status = tcsm_pkg::ST_DROPPED;
                    end
                end else if (cs_reg > tcsm_pkg::S_LAST_ACK) begin
                    status = tcsm_pkg::ST_DROPPED;
                end else begin
                    if (q_data.plen_nz)
                        ok = rcv_wnd_reg != '0 && rcv_nxt_reg <= seq &&
                             (seq < lim || spl - 32'd1 < lim);
                    else if (rcv_wnd_reg != '0)
                        ok = rcv_nxt_reg <= seq && seq < lim;
                    else
                        ok = seq == rcv_nxt_reg;
                    if (!ok) begin
                        if ((flg & tcsm_pkg::F_RST) == '0) begin
                            e_seq[0] = snd_nxt_reg; e_ack[0] = rcv_nxt_reg;
                            e_flg[0] = tcsm_pkg::F_ACK; ntx = 2'd1;
                        end
                        status = tcsm_pkg::ST_DROPPED;
                    end else if ((flg & tcsm_pkg::F_RST) != '0) begin
                        cs_n = (cs_reg == tcsm_pkg::S_SYN_RCVD && pas_reg) ?
                               tcsm_pkg::S_LISTEN : tcsm_pkg::S_CLOSED;
                        status = tcsm_pkg::ST_RESET;
                    end else if ((flg & tcsm_pkg::F_SYN) != '0) begin
                        e_ack[0] = rcv_nxt_reg; e_flg[0] = tcsm_pkg::F_RST; ntx = 2'd1;
                        cs_n = tcsm_pkg::S_CLOSED; status = tcsm_pkg::ST_RESET;
                    end else begin
                        do_tail = 1'b1;
                        if ((flg & tcsm_pkg::F_ACK) != '0) begin
                            if (cs_reg == tcsm_pkg::S_SYN_RCVD) begin
                                if (snd_una_reg <= ack && ack <= snd_nxt_reg) begin
                                    cs_n = tcsm_pkg::S_ESTAB;
                                    status = pas_reg ? tcsm_pkg::ST_ACCEPTED :
                                                       tcsm_pkg::ST_CONNECTED;
                                end else begin
                                    e_seq[0] = ack; e_ack[0] = rcv_nxt_reg;
                                    e_flg[0] = tcsm_pkg::F_RST; ntx = 2'd1;
                                end
                            end else if (cs_reg == tcsm_pkg::S_ESTAB ||
                                         cs_reg == tcsm_pkg::S_FW1 ||
                                         cs_reg == tcsm_pkg::S_FW2 ||
                                         cs_reg == tcsm_pkg::S_CLOSE_WAIT) begin
                                if (snd_una_reg <= ack && ack <= snd_nxt_reg) begin
                                    snd_una_n = ack;
                                    if (wl1_reg < seq || (wl1_reg == seq && wl2_reg <= ack))
                                    begin
                                        snd_wnd_n = q_data.ev.win;
                                        wl1_n = seq; wl2_n = ack;
                                    end
                                end else if (ack > snd_nxt_reg) begin
                                    e_seq[0] = snd_nxt_reg; e_ack[0] = rcv_nxt_reg;
                                    e_flg[0] = tcsm_pkg::F_ACK; ntx = 2'd1;
                                    status = tcsm_pkg::ST_DROPPED; do_tail = 1'b0;
                                end
                                if (do_tail && cs_reg == tcsm_pkg::S_FW1 &&
                                    ack == snd_nxt_reg)
                                    cs_n = tcsm_pkg::S_FW2;
                            end else if (cs_reg == tcsm_pkg::S_CLOSING) begin
                                if (ack == snd_nxt_reg) cs_n = tcsm_pkg::S_TIME_WAIT;
                            end else if (cs_reg == tcsm_pkg::S_LAST_ACK) begin
                                if (ack == snd_nxt_reg) begin
                                    cs_n = tcsm_pkg::S_CLOSED; do_tail = 1'b0;
                                end
                            end
                        end
                    end
                end
                // segments queued so far carry the window as it stands here
                ntx_pre = ntx;
                win_pre = rcv_wnd_n;
                // urgent, text and FIN handling on the updated state
                if (do_tail) begin
                    in_data = cs_n == tcsm_pkg::S_ESTAB || cs_n == tcsm_pkg::S_FW1 ||
                              cs_n == tcsm_pkg::S_FW2;
                    if ((flg & tcsm_pkg::F_URG) != '0 && in_data &&
                        q_data.ev.urg > rcv_up_reg)
                        rcv_up_n = q_data.ev.urg;
                    if (in_data && q_data.plen_nz) begin
                        acc = (q_data.ev.plen < rcv_wnd_reg) ? q_data.ev.plen : rcv_wnd_reg;
                        doff = rbs_reg - rcv_wnd_reg;
                        dlen = acc;
                        rcv_nxt_n = dseq + {16'd0, acc};
                        rcv_wnd_n = rcv_wnd_reg - acc;
                        e_seq[ntx] = snd_nxt_reg; e_ack[ntx] = rcv_nxt_n;
                        e_flg[ntx] = tcsm_pkg::F_ACK;
                        ntx = ntx + 2'd1;
                        status = tcsm_pkg::ST_DATA;
                    end
                    if ((flg & tcsm_pkg::F_FIN) != '0) begin
                        rcv_nxt_n = dseq + {16'd0, acc} + 32'd1;
                        e_seq[ntx] = snd_nxt_reg; e_ack[ntx] = rcv_nxt_n;
                        e_flg[ntx] = tcsm_pkg::F_ACK;
                        ntx = ntx + 2'd1;
                        if (cs_n == tcsm_pkg::S_SYN_RCVD || cs_n == tcsm_pkg::S_ESTAB)
                            cs_n = tcsm_pkg::S_CLOSE_WAIT;
                        else if (cs_n == tcsm_pkg::S_FW1)
                            cs_n = tcsm_pkg::S_CLOSING;
                        else if (cs_n == tcsm_pkg::S_FW2)
                            cs_n = tcsm_pkg::S_TIME_WAIT;
                        status = tcsm_pkg::ST_PEER_FIN;
                    end
                end
            end
            tcsm_pkg::M_ACTIVE, tcsm_pkg::M_PASSIVE: begin
                if (cs_reg != tcsm_pkg::S_CLOSED) begin
                    status = tcsm_pkg::ST_REFUSED;
                end else if (mode == tcsm_pkg::M_ACTIVE) begin
                    pas_n = 1'b0; rcv_wnd_n = rbs_reg; iss_n = q_data.ev.niss;
                    e_seq[0] = q_data.ev.niss; e_flg[0] = tcsm_pkg::F_SYN; ntx = 2'd1;
                    snd_una_n = q_data.ev.niss;
                    snd_nxt_n = q_data.ev.niss + 32'd1;
                    cs_n = tcsm_pkg::S_SYN_SENT;
                end else begin
                    pas_n = 1'b1; cs_n = tcsm_pkg::S_LISTEN;
                end
            end
            default: begin
                if (cs_reg == tcsm_pkg::S_CLOSED) begin
                end else if (cs_reg == tcsm_pkg::S_LISTEN ||
                             cs_reg == tcsm_pkg::S_SYN_SENT) begin
                    cs_n = tcsm_pkg::S_CLOSED;
                end else if (cs_reg == tcsm_pkg::S_SYN_RCVD ||
                             cs_reg == tcsm_pkg::S_ESTAB ||
                             cs_reg == tcsm_pkg::S_CLOSE_WAIT) begin
                    e_seq[0] = snd_nxt_reg; e_ack[0] = rcv_nxt_reg;
                    e_flg[0] = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK; ntx = 2'd1;
                    snd_nxt_n = snd_nxt_reg + 32'd1;
                    cs_n = (cs_reg == tcsm_pkg::S_CLOSE_WAIT) ?
                           tcsm_pkg::S_LAST_ACK : tcsm_pkg::S_FW1;
                end else begin
                    status = tcsm_pkg::ST_REFUSED;
                end
            end
        endcase
        // window is the value at emission: text and FIN ACKs follow the text intake
        for (int i = 0; i < 3; i++) begin
            tx_n[i].seq   = e_seq[i];
            tx_n[i].ack   = e_ack[i];
            tx_n[i].flags = e_flg[i];
            tx_n[i].win   = (2'(i) < ntx_pre) ? win_pre : rcv_wnd_n;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rbs_reg <= 16'hffff;
            cs_reg <= tcsm_pkg::S_CLOSED;
            snd_nxt_reg <= '0; snd_una_reg <= '0; snd_wnd_reg <= '0;
            wl1_reg <= '0; wl2_reg <= '0; iss_reg <= '0; irs_reg <= '0;
            rcv_nxt_reg <= '0; rcv_wnd_reg <= '0; rcv_up_reg <= '0; pas_reg <= 1'b0;
            busy_reg <= 1'b0; idx_reg <= '0; ntx_reg <= '0;
        end else begin
            if (cfg_valid) rbs_reg <= cfg_data;
            if (take) begin
                cs_reg <= cs_n; snd_nxt_reg <= snd_nxt_n; snd_una_reg <= snd_una_n;
                snd_wnd_reg <= snd_wnd_n; wl1_reg <= wl1_n; wl2_reg <= wl2_n;
                iss_reg <= iss_n; irs_reg <= irs_n; rcv_nxt_reg <= rcv_nxt_n;
                rcv_wnd_reg <= rcv_wnd_n; rcv_up_reg <= rcv_up_n; pas_reg <= pas_n;
                busy_reg <= 1'b1; idx_reg <= '0; ntx_reg <= ntx;
            end else if (fin_item) begin
                busy_reg <= 1'b0;
            end else if (out_valid && out_ready) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < 3; i++) tx_reg[i] <= tx_n[i];
            rcs_reg <= cs_n; rst_reg <= status; roff_reg <= doff; rlen_reg <= dlen;
        end
    end

    `TCSM_ASSERT_IMP(a_last_bounds, aclk, aresetn, out_valid, idx_reg < 2'd3)
    `TCSM_ASSERT_IMP(a_take_when_free, aclk, aresetn, take, !busy_reg || fin_item)
    `TCSM_ASSERT_NXT(a_busy_after_take, aclk, aresetn, take, busy_reg && idx_reg == 2'd0)
    `TCSM_ASSERT_IMP(a_sv_count, aclk, aresetn, out_valid && out_res.send_valid, ntx_reg != 2'd0)
endmodule

// ===== src/tcp_connection_state_machine.sv =====
// Flow: an event is written into the two-entry front queue, taken from it by
// the back end once the back end is free, and its results are registered.
// Throughput: one event per cycle when each gives one result and m_tready is
// high; an event with n segments (up to 3) holds the back end for n results.
// Reset: synchronous active-low aresetn; connection CLOSED, all variables zero,
// receive buffer size 65535.
module tcp_connection_state_machine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0] seg_seq[33:2] seg_ack[65:34] seg_flags[71:66] seg_window[87:72]
    // seg_urgent[103:88] payload_len[119:104] new_iss[151:120]
    input  logic [151:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // send_valid[0] send_seq[32:1] send_ack[64:33] send_flags[70:65]
    // send_window[86:71] conn_state[90:87] status[93:91] deliver_offset[109:94]
    // deliver_len[125:110]
    output logic [127:0] m_tdata,
    output logic        m_tlast
);
    tcsm_pkg::event_t  ev;
    tcsm_pkg::cls_t    qd;
    tcsm_pkg::result_t res;
    logic q_valid, q_ready;

    assign ev.mode  = s_tdata[1:0];
    assign ev.seq   = s_tdata[33:2];
    assign ev.ack   = s_tdata[65:34];
    assign ev.flags = s_tdata[71:66];
    assign ev.win   = s_tdata[87:72];
    assign ev.urg   = s_tdata[103:88];
    assign ev.plen  = s_tdata[119:104];
    assign ev.niss  = s_tdata[151:120];

    tcsm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_ev(ev),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(qd)
    );

    tcsm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(qd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {2'b00, res.deliver_len, res.deliver_offset, res.status,
                      res.conn_state, res.seg.win, res.seg.flags, res.seg.ack,
                      res.seg.seq, res.send_valid};
    assign m_tlast = res.last;
endmodule
